// ===== rtl/bbsf_pkg.sv =====
package bbsf_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int FILL_W    = ADDR_W + 1;
    localparam int CAP_W     = 11;
    localparam int MAX_BURST = 64;
    localparam int CNT_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int TOT_W     = 32;
    localparam int MODE_W    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 3'd0,
        MODE_PEEK  = 3'd1,
        MODE_POP   = 3'd2,
        MODE_READ  = 3'd3,
        MODE_END   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              byte_valid;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill_level;
        logic [FILL_W-1:0] space_left;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              ended;
        logic              at_eof;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_obuf_stat;

endpackage

// ===== rtl/bbsf_ram.sv =====
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bbsf_obuf.sv =====
module bbsf_obuf
    import bbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_result,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result,
    output t_obuf_stat o_stat
);

    t_result    r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_valid  = (r_cnt != 2'd0);
    assign w_pop    = o_valid && i_ready;
    assign o_result = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
        if (i_push) begin
            r_buf[r_wp] <= i_result;
        end
    end

    always_comb begin
        o_stat.count = r_cnt;
        o_stat.pop   = w_pop;
    end

endmodule

// ===== rtl/bbsf_ctrl.sv =====
module bbsf_ctrl
    import bbsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [BYTE_W-1:0] i_data_in,
    input  logic [CNT_W-1:0]  i_count,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [BYTE_W-1:0] o_ram_wdata,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [BYTE_W-1:0] i_ram_rdata,
    input  t_obuf_stat        i_ostat,
    output logic              o_push,
    output t_result           o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_BURST
    } t_state;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_cap;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [TOT_W-1:0]   r_wr_tot, n_wr_tot;
    logic [TOT_W-1:0]   r_rd_tot, n_rd_tot;
    logic               r_done, n_done;
    logic               r_acc, n_acc;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [ADDR_W-1:0]  r_rd_addr, n_rd_addr;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;

    logic               w_accept;
    logic [CNT_W-1:0]   w_cnt_sat;
    logic [CNT_W-1:0]   w_n;
    logic [FILL_W-1:0]  w_eff_cap;
    logic               w_room;
    logic [2:0]         w_load;
    logic               w_can_issue;
    logic               w_single_push;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_eff_cap = (r_cap > CAP_W'(DEPTH)) ? FILL_W'(DEPTH) : FILL_W'(r_cap);
    assign w_room    = (r_fill < w_eff_cap);
    assign w_cnt_sat = (i_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : i_count;
    assign w_n       = (FILL_W'(w_cnt_sat) < r_fill) ? w_cnt_sat : CNT_W'(r_fill);

    assign w_load      = 3'(i_ostat.count) + 3'(r_pend) - 3'(i_ostat.pop);
    assign w_can_issue = (w_load < 3'd2);

    assign o_ram_we    = w_accept && (t_mode'(i_mode) == MODE_WRITE) && w_room;
    assign o_ram_waddr = ADDR_W'(r_head + ADDR_W'(r_fill));
    assign o_ram_wdata = i_data_in;
    assign o_ram_re    = (r_state == S_BURST) && w_can_issue;
    assign o_ram_raddr = r_rd_addr;

    assign w_single_push = (r_state == S_SINGLE) && w_can_issue;
    assign o_push        = r_pend || w_single_push;

    always_comb begin
        o_result.data_out      = r_pend ? i_ram_rdata : '0;
        o_result.byte_valid    = r_pend;
        o_result.last          = r_pend ? r_pend_last : 1'b1;
        o_result.accepted      = r_pend ? 1'b0 : r_acc;
        o_result.fill_level    = r_fill;
        o_result.space_left    = w_room ? (w_eff_cap - r_fill) : '0;
        o_result.total_written = r_wr_tot;
        o_result.total_read    = r_rd_tot;
        o_result.ended         = r_done;
        o_result.at_eof        = r_done && (r_fill == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_wr_tot    = r_wr_tot;
        n_rd_tot    = r_rd_tot;
        n_done      = r_done;
        n_acc       = r_acc;
        n_left      = r_left;
        n_rd_addr   = r_rd_addr;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_acc     = 1'b0;
                    n_left    = w_n;
                    n_rd_addr = r_head;
                    n_state   = S_SINGLE;
                    unique case (t_mode'(i_mode))
                        MODE_WRITE: begin
                            n_acc = w_room;
                            if (w_room) begin
                                n_fill   = r_fill + FILL_W'(1);
                                n_wr_tot = r_wr_tot + TOT_W'(1);
                            end
                        end
                        MODE_PEEK: begin
                            if (w_n != '0) begin
                                n_state = S_BURST;
                            end
                        end
                        MODE_READ: begin
                            n_head   = ADDR_W'(r_head + ADDR_W'(w_n));
                            n_fill   = r_fill - FILL_W'(w_n);
                            n_rd_tot = r_rd_tot + TOT_W'(w_n);
                            if (w_n != '0) begin
                                n_state = S_BURST;
                            end
                        end
                        MODE_POP: begin
                            n_head   = ADDR_W'(r_head + ADDR_W'(w_n));
                            n_fill   = r_fill - FILL_W'(w_n);
                            n_rd_tot = r_rd_tot + TOT_W'(w_n);
                        end
                        MODE_END: begin
                            n_done = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SINGLE: begin
                if (w_can_issue) begin
                    n_state = S_IDLE;
                end
            end
            S_BURST: begin
                if (w_can_issue) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_left == CNT_W'(1));
                    n_left      = r_left - CNT_W'(1);
                    n_rd_addr   = ADDR_W'(r_rd_addr + ADDR_W'(1));
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= CAP_W'(1024);
            r_head   <= '0;
            r_fill   <= '0;
            r_wr_tot <= '0;
            r_rd_tot <= '0;
            r_done   <= 1'b0;
            r_pend   <= 1'b0;
            r_acc    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_wr_tot <= n_wr_tot;
            r_rd_tot <= n_rd_tot;
            r_done   <= n_done;
            r_pend   <= n_pend;
            r_acc    <= n_acc;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
        r_left      <= n_left;
        r_rd_addr   <= n_rd_addr;
        r_pend_last <= n_pend_last;
    end

endmodule

// ===== rtl/bounded_byte_stream_fifo.sv =====
// Byte FIFO of 1024 entries whose usable capacity is set by the configuration
// register (reset value 1024, values above the store size act as 1024). Each
// transaction on the slave side carries one command: write a byte, peek, read or
// pop up to 64 bytes, or mark the end of input. Every command except a peek or read
// that returns bytes yields one status transaction; a peek or read of n bytes yields
// n transactions, the last one flagged with tlast. A peek or read streams its bytes
// one byte per cycle, while the output buffer has room, from the single read port of
// the byte store, with a two-entry output buffer so that streaming continues while
// the master side is ready. No new command is taken until the current one is done.
// Each result carries the status after the whole command. The capacity register may be
// written only while no command is in progress.
module bounded_byte_stream_fifo
    import bbsf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [10:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,  // data_in[7:0], count[14:8], zero[15]
    input  logic [2:0]   s_axis_tuser,  // mode[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // data_out, accepted, fill_level, space_left,
                                        // total_written, total_read, ended, at_eof, zero
    output logic         m_axis_tuser,  // byte_valid
    output logic         m_axis_tlast
);

    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;
    t_obuf_stat        w_ostat;
    logic              w_push;
    t_result           w_result;
    t_result           w_out;

    assign o_cfg_ready = 1'b1;

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bbsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_data_in   (s_axis_tdata[7:0]),
        .i_count     (s_axis_tdata[14:8]),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .i_ostat     (w_ostat),
        .o_push      (w_push),
        .o_result    (w_result)
    );

    bbsf_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out),
        .o_stat   (w_ostat)
    );

    assign m_axis_tdata = {7'd0, w_out.at_eof, w_out.ended, w_out.total_read,
                           w_out.total_written, w_out.space_left, w_out.fill_level,
                           w_out.accepted, w_out.data_out};
    assign m_axis_tuser = w_out.byte_valid;
    assign m_axis_tlast = w_out.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && (w_ostat.count == 2'd2) && !w_ostat.pop))
        else $error("output buffer overflow");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:9] <= 11'(DEPTH)))
        else $error("fill level beyond store size");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new command taken while one is in progress");

endmodule
